/* hdl/tqcp_pkg.sv */
// Shared types, codes and default sizes for the two-queue cache policy block.
`timescale 1ns / 1ps

package tqcp_pkg;

    // Default sizes handed to the top level
    localparam int LRU_DEPTH_DEF  = 8;
    localparam int FIFO_DEPTH_DEF = 8;
    localparam int KEY_WIDTH_DEF  = 64;
    localparam int AGE_WIDTH_DEF  = 16;

    // Fixed widths of the port fields
    localparam int LOOKUP_KEY_W = 64;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 4;
    localparam int SLOT_W       = 4;
    localparam int PROMOTED_W   = 3;
    localparam int TOTAL_W      = 32;

    // Width used for small index sums and compares (depths stay below 128)
    localparam int SUM_W = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_LRU_IN_USE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIFO_IN_USE = 2'd1;

    // Reset value of both size registers
    localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = 4'd8;

    // Lookup outcome codes
    typedef enum logic [1:0] {
        OUT_LRU_HIT  = 2'd0,
        OUT_FIFO_HIT = 2'd1,
        OUT_MISS     = 2'd2
    } outcome_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LRU_WALK,
        ST_FIFO_WALK,
        ST_PROMOTE,
        ST_WRAP,
        ST_FINISH
    } state_t;

endpackage

/* hdl/tqcp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tqcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* hdl/two_queue_cache_policy_top.sv */
// Two-queue (2Q) cache replacement policy: sequencer, stores and counters.
// A lookup walks the LRU slots in use, then the FIFO slots in use (nl, nf = slots in use);
// an LRU hit skips the FIFO walk, and a FIFO hit promotes the key into the oldest LRU slot.
// A miss after the FIFO size shrank first subtracts the size from the pointer until it fits.
// One lookup at a time: the next word is taken in the cycle after the result loads.
// Reset clears control, valid bits and counters at once; no clearing pass is needed.
`timescale 1ns / 1ps

module two_queue_cache_policy_top #(
    parameter int LRU_DEPTH  = tqcp_pkg::LRU_DEPTH_DEF,
    parameter int FIFO_DEPTH = tqcp_pkg::FIFO_DEPTH_DEF,
    parameter int KEY_WIDTH  = tqcp_pkg::KEY_WIDTH_DEF,
    parameter int AGE_WIDTH  = tqcp_pkg::AGE_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // lookup channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [tqcp_pkg::LOOKUP_KEY_W-1:0] lookup_key,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [1:0]                        outcome,
    output logic [tqcp_pkg::SLOT_W-1:0]       slot_index,
    output logic [tqcp_pkg::PROMOTED_W-1:0]   promoted_slot,
    output logic [tqcp_pkg::TOTAL_W-1:0]      hit_total,
    output logic [tqcp_pkg::TOTAL_W-1:0]      miss_total,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tqcp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [tqcp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int LRU_IW    = (LRU_DEPTH > 1) ? $clog2(LRU_DEPTH) : 1;
    localparam int FIFO_IW   = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int NL_W      = $clog2(LRU_DEPTH + 1);
    localparam int NF_W      = $clog2(FIFO_DEPTH + 1);
    localparam int MAX_DEPTH = (LRU_DEPTH > FIFO_DEPTH) ? LRU_DEPTH : FIFO_DEPTH;
    localparam int CNT_W     = $clog2(MAX_DEPTH + 1);
    localparam int SUM_W     = tqcp_pkg::SUM_W;
    localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};

    // Control state
    tqcp_pkg::state_t                   state_reg, state_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    logic                               found_reg, found_next;
    logic [FIFO_IW-1:0]                 ptr_reg, ptr_next;
    logic [tqcp_pkg::TOTAL_W-1:0]       hit_cnt_reg, hit_cnt_next;
    logic [tqcp_pkg::TOTAL_W-1:0]       miss_cnt_reg, miss_cnt_next;
    logic [tqcp_pkg::CFG_DATA_W-1:0]    lru_cfg_reg, lru_cfg_next;
    logic [tqcp_pkg::CFG_DATA_W-1:0]    fifo_cfg_reg, fifo_cfg_next;
    logic [LRU_DEPTH-1:0]               lru_valid_reg, lru_valid_next;
    logic [LRU_DEPTH-1:0]               age_ok_reg, age_ok_next;
    logic [FIFO_DEPTH-1:0]              fifo_valid_reg, fifo_valid_next;
    logic                               out_valid_reg, out_valid_next;

    // Working payload
    logic [KEY_WIDTH-1:0]               key_reg, key_next;
    logic [LRU_IW-1:0]                  oldest_reg, oldest_next;
    logic [AGE_WIDTH-1:0]               oldest_age_reg, oldest_age_next;
    tqcp_pkg::outcome_t                 outcome_reg, outcome_next;
    logic [tqcp_pkg::SLOT_W-1:0]        slot_reg, slot_next;
    logic [tqcp_pkg::PROMOTED_W-1:0]    promoted_reg, promoted_next;

    // Result word held for the downstream side
    tqcp_pkg::outcome_t                 res_outcome_reg, res_outcome_next;
    logic [tqcp_pkg::SLOT_W-1:0]        res_slot_reg, res_slot_next;
    logic [tqcp_pkg::PROMOTED_W-1:0]    res_promoted_reg, res_promoted_next;
    logic [tqcp_pkg::TOTAL_W-1:0]       res_hit_reg, res_hit_next;
    logic [tqcp_pkg::TOTAL_W-1:0]       res_miss_reg, res_miss_next;

    // RAM ports
    logic                   lru_key_we, lru_key_re;
    logic [LRU_IW-1:0]      lru_key_waddr;
    logic [KEY_WIDTH-1:0]   lru_key_rdata;
    logic                   age_we, age_re;
    logic [LRU_IW-1:0]      age_waddr;
    logic [AGE_WIDTH-1:0]   age_wdata, age_rdata;
    logic                   fifo_key_we, fifo_key_re;
    logic [FIFO_IW-1:0]     fifo_key_waddr;
    logic [KEY_WIDTH-1:0]   fifo_key_rdata;

    // Walk helpers
    logic [NL_W-1:0]        nl;
    logic [NF_W-1:0]        nf;
    logic [CNT_W-1:0]       ev_cnt;
    logic [LRU_IW-1:0]      lru_rd, lru_ev;
    logic [FIFO_IW-1:0]     fifo_rd, fifo_ev;
    logic                   walk_eval, lru_last, fifo_last;
    logic                   lru_hit_here, fifo_hit_here;
    logic [AGE_WIDTH-1:0]   age_cur, age_inc;
    logic                   ptr_ge, out_free;
    logic [SUM_W-1:0]       ptr_sub, ptr_inc, lru_slot_sum, fifo_slot_sum, ptr_slot_sum;
    logic [SUM_W-1:0]       lru_ev_w, oldest_w;

    // Slot counts clamped to one up to the store depth
    always_comb
    begin
        if (lru_cfg_reg == '0)
            nl = NL_W'(1);
        else if (SUM_W'(lru_cfg_reg) > SUM_W'(LRU_DEPTH))
            nl = NL_W'(LRU_DEPTH);
        else
            nl = NL_W'(lru_cfg_reg);

        if (fifo_cfg_reg == '0)
            nf = NF_W'(1);
        else if (SUM_W'(fifo_cfg_reg) > SUM_W'(FIFO_DEPTH))
            nf = NF_W'(FIFO_DEPTH);
        else
            nf = NF_W'(fifo_cfg_reg);
    end

    // Read at cnt, evaluate the slot read in the previous cycle (cnt - 1)
    assign ev_cnt    = cnt_reg - CNT_W'(1);
    assign lru_rd    = cnt_reg[LRU_IW-1:0];
    assign lru_ev    = ev_cnt[LRU_IW-1:0];
    assign fifo_rd   = cnt_reg[FIFO_IW-1:0];
    assign fifo_ev   = ev_cnt[FIFO_IW-1:0];
    assign walk_eval = (cnt_reg != '0);
    assign lru_last  = (SUM_W'(cnt_reg) == SUM_W'(nl));
    assign fifo_last = (SUM_W'(cnt_reg) == SUM_W'(nf));

    assign lru_hit_here  = walk_eval && !found_reg && lru_valid_reg[lru_ev]
                           && (lru_key_rdata == key_reg);
    assign fifo_hit_here = walk_eval && fifo_valid_reg[fifo_ev]
                           && (fifo_key_rdata == key_reg);

    // Saturating age step; an age never written reads as zero
    assign age_cur = age_ok_reg[lru_ev] ? age_rdata : '0;
    assign age_inc = (age_cur == AGE_MAX) ? age_cur : age_cur + AGE_WIDTH'(1);

    // Pointer wrap and combined slot sums
    assign ptr_ge        = (SUM_W'(ptr_reg) >= SUM_W'(nf));
    assign ptr_sub       = SUM_W'(ptr_reg) - SUM_W'(nf);
    assign ptr_inc       = SUM_W'(ptr_reg) + SUM_W'(1);
    assign lru_ev_w      = SUM_W'(lru_ev);
    assign oldest_w      = SUM_W'(oldest_reg);
    assign lru_slot_sum  = lru_ev_w;
    assign fifo_slot_sum = SUM_W'(nl) + SUM_W'(fifo_ev);
    assign ptr_slot_sum  = SUM_W'(nl) + SUM_W'(ptr_reg);

    assign out_free  = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != tqcp_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tqcp_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = tqcp_pkg::ST_LRU_WALK;
            end
            tqcp_pkg::ST_LRU_WALK:
            begin
                if (lru_last)
                    state_next = (found_reg || lru_hit_here) ? tqcp_pkg::ST_FINISH
                                                             : tqcp_pkg::ST_FIFO_WALK;
            end
            tqcp_pkg::ST_FIFO_WALK:
            begin
                if (fifo_hit_here)
                    state_next = tqcp_pkg::ST_PROMOTE;
                else if (fifo_last)
                    state_next = tqcp_pkg::ST_WRAP;
            end
            tqcp_pkg::ST_PROMOTE:
            begin
                state_next = tqcp_pkg::ST_FINISH;
            end
            tqcp_pkg::ST_WRAP:
            begin
                if (!ptr_ge)
                    state_next = tqcp_pkg::ST_FINISH;
            end
            tqcp_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = tqcp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tqcp_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath, store controls and result word
    always_comb
    begin
        cnt_next          = cnt_reg;
        found_next        = found_reg;
        ptr_next          = ptr_reg;
        hit_cnt_next      = hit_cnt_reg;
        miss_cnt_next     = miss_cnt_reg;
        lru_cfg_next      = lru_cfg_reg;
        fifo_cfg_next     = fifo_cfg_reg;
        lru_valid_next    = lru_valid_reg;
        age_ok_next       = age_ok_reg;
        fifo_valid_next   = fifo_valid_reg;
        out_valid_next    = out_valid_reg;
        key_next          = key_reg;
        oldest_next       = oldest_reg;
        oldest_age_next   = oldest_age_reg;
        outcome_next      = outcome_reg;
        slot_next         = slot_reg;
        promoted_next     = promoted_reg;
        res_outcome_next  = res_outcome_reg;
        res_slot_next     = res_slot_reg;
        res_promoted_next = res_promoted_reg;
        res_hit_next      = res_hit_reg;
        res_miss_next     = res_miss_reg;

        lru_key_we     = 1'b0;
        lru_key_re     = 1'b0;
        lru_key_waddr  = oldest_reg;
        age_we         = 1'b0;
        age_re         = 1'b0;
        age_waddr      = lru_ev;
        age_wdata      = '0;
        fifo_key_we    = 1'b0;
        fifo_key_re    = 1'b0;
        fifo_key_waddr = ptr_reg;

        // configuration writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                tqcp_pkg::CFG_LRU_IN_USE:  lru_cfg_next  = cfg_data;
                tqcp_pkg::CFG_FIFO_IN_USE: fifo_cfg_next = cfg_data;
                default: ;
            endcase
        end

        // result word taken downstream
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            tqcp_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    key_next        = lookup_key[KEY_WIDTH-1:0];
                    cnt_next        = '0;
                    found_next      = 1'b0;
                    oldest_next     = '0;
                    oldest_age_next = '0;
                    outcome_next    = tqcp_pkg::OUT_MISS;
                    slot_next       = '0;
                    promoted_next   = '0;
                end
            end
            tqcp_pkg::ST_LRU_WALK:
            begin
                lru_key_re = !lru_last;
                age_re     = !lru_last;
                if (walk_eval)
                begin
                    // age every slot in use, note the first oldest, clear a hit
                    age_we              = 1'b1;
                    age_wdata           = lru_hit_here ? '0 : age_inc;
                    age_ok_next[lru_ev] = 1'b1;
                    if (age_inc > oldest_age_reg)
                    begin
                        oldest_age_next = age_inc;
                        oldest_next     = lru_ev;
                    end
                    if (lru_hit_here)
                    begin
                        found_next   = 1'b1;
                        outcome_next = tqcp_pkg::OUT_LRU_HIT;
                        slot_next    = lru_slot_sum[tqcp_pkg::SLOT_W-1:0];
                    end
                end
                if (lru_last)
                begin
                    cnt_next = '0;
                    if (found_reg || lru_hit_here)
                        hit_cnt_next = hit_cnt_reg + 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            tqcp_pkg::ST_FIFO_WALK:
            begin
                fifo_key_re = !fifo_last;
                if (fifo_hit_here)
                begin
                    found_next   = 1'b1;
                    outcome_next = tqcp_pkg::OUT_FIFO_HIT;
                    slot_next    = fifo_slot_sum[tqcp_pkg::SLOT_W-1:0];
                end
                else if (!fifo_last)
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            tqcp_pkg::ST_PROMOTE:
            begin
                // copy the key into the oldest LRU slot, FIFO copy stays
                lru_key_we              = 1'b1;
                age_we                  = 1'b1;
                age_waddr               = oldest_reg;
                age_wdata               = '0;
                age_ok_next[oldest_reg] = 1'b1;
                lru_valid_next[oldest_reg] = 1'b1;
                promoted_next           = oldest_w[tqcp_pkg::PROMOTED_W-1:0];
                hit_cnt_next            = hit_cnt_reg + 1'b1;
            end
            tqcp_pkg::ST_WRAP:
            begin
                if (ptr_ge)
                begin
                    // bring the pointer back under a shrunken size
                    ptr_next = ptr_sub[FIFO_IW-1:0];
                end
                else
                begin
                    fifo_key_we              = 1'b1;
                    fifo_valid_next[ptr_reg] = 1'b1;
                    slot_next     = ptr_slot_sum[tqcp_pkg::SLOT_W-1:0];
                    outcome_next  = tqcp_pkg::OUT_MISS;
                    miss_cnt_next = miss_cnt_reg + 1'b1;
                    ptr_next      = (ptr_inc == SUM_W'(nf)) ? '0 : ptr_inc[FIFO_IW-1:0];
                end
            end
            tqcp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    res_outcome_next  = outcome_reg;
                    res_slot_next     = slot_reg;
                    res_promoted_next = promoted_reg;
                    res_hit_next      = hit_cnt_reg;
                    res_miss_next     = miss_cnt_reg;
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tqcp_pkg::ST_IDLE;
            cnt_reg        <= '0;
            found_reg      <= 1'b0;
            ptr_reg        <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            lru_cfg_reg    <= tqcp_pkg::CFG_SIZE_RESET;
            fifo_cfg_reg   <= tqcp_pkg::CFG_SIZE_RESET;
            lru_valid_reg  <= '0;
            age_ok_reg     <= '0;
            fifo_valid_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            found_reg      <= found_next;
            ptr_reg        <= ptr_next;
            hit_cnt_reg    <= hit_cnt_next;
            miss_cnt_reg   <= miss_cnt_next;
            lru_cfg_reg    <= lru_cfg_next;
            fifo_cfg_reg   <= fifo_cfg_next;
            lru_valid_reg  <= lru_valid_next;
            age_ok_reg     <= age_ok_next;
            fifo_valid_reg <= fifo_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg          <= key_next;
        oldest_reg       <= oldest_next;
        oldest_age_reg   <= oldest_age_next;
        outcome_reg      <= outcome_next;
        slot_reg         <= slot_next;
        promoted_reg     <= promoted_next;
        res_outcome_reg  <= res_outcome_next;
        res_slot_reg     <= res_slot_next;
        res_promoted_reg <= res_promoted_next;
        res_hit_reg      <= res_hit_next;
        res_miss_reg     <= res_miss_next;
    end

    // LRU key store
    tqcp_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (LRU_DEPTH)
    ) u_lru_keys (
        .clk   (clk),
        .we    (lru_key_we),
        .waddr (lru_key_waddr),
        .wdata (key_reg),
        .re    (lru_key_re),
        .raddr (lru_rd),
        .rdata (lru_key_rdata)
    );

    // LRU age store
    tqcp_ram #(
        .WIDTH (AGE_WIDTH),
        .DEPTH (LRU_DEPTH)
    ) u_lru_ages (
        .clk   (clk),
        .we    (age_we),
        .waddr (age_waddr),
        .wdata (age_wdata),
        .re    (age_re),
        .raddr (lru_rd),
        .rdata (age_rdata)
    );

    // FIFO key store
    tqcp_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_keys (
        .clk   (clk),
        .we    (fifo_key_we),
        .waddr (fifo_key_waddr),
        .wdata (key_reg),
        .re    (fifo_key_re),
        .raddr (fifo_rd),
        .rdata (fifo_key_rdata)
    );

    // Result port
    assign out_valid     = out_valid_reg;
    assign outcome       = res_outcome_reg;
    assign slot_index    = res_slot_reg;
    assign promoted_slot = res_promoted_reg;
    assign hit_total     = res_hit_reg;
    assign miss_total    = res_miss_reg;

    // Checks on the sequencer
    a_lru_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tqcp_pkg::ST_LRU_WALK) |-> (SUM_W'(cnt_reg) <= SUM_W'(nl)))
        else $error("LRU walk counter ran past the slots in use");

    a_fifo_walk_unfound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tqcp_pkg::ST_FIFO_WALK) |-> !found_reg)
        else $error("FIFO walk entered after a hit");

    a_promote_found: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tqcp_pkg::ST_PROMOTE) |-> (found_reg && oldest_w < SUM_W'(nl)))
        else $error("promotion without a FIFO hit or outside the LRU slots in use");

    a_miss_ptr_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tqcp_pkg::ST_WRAP && !ptr_ge) |=> (SUM_W'(ptr_reg) < SUM_W'(nf)))
        else $error("FIFO pointer left beyond the slots in use");

    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == tqcp_pkg::ST_FINISH && out_free) |=> out_valid_reg)
        else $error("finished lookup produced no result word");

endmodule
